>>> src/u8sd_pkg.sv
package u8sd_pkg;

	localparam int CP_BITS  = 21;
	localparam int IDX_BITS = 16;
	localparam int NB_BITS  = 3;

	localparam logic [IDX_BITS-1:0] IDX_MAX = '1;

	// Depth of the queue between the decode front and the output back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// Lead byte thresholds and masks.
	localparam logic [7:0] LEAD_TWO   = 8'd128;
	localparam logic [7:0] LEAD_THREE = 8'd224;
	localparam logic [7:0] LEAD_FOUR  = 8'd240;
	localparam logic [5:0] CONT_MASK  = 6'd63;

	// Whitespace code points.
	localparam logic [CP_BITS-1:0] WS_TAB     = 21'h000009;
	localparam logic [CP_BITS-1:0] WS_CR      = 21'h00000D;
	localparam logic [CP_BITS-1:0] WS_SPACE   = 21'h000020;
	localparam logic [CP_BITS-1:0] WS_NEL     = 21'h000085;
	localparam logic [CP_BITS-1:0] WS_NBSP    = 21'h0000A0;
	localparam logic [CP_BITS-1:0] WS_OGHAM   = 21'h001680;
	localparam logic [CP_BITS-1:0] WS_ENQUAD  = 21'h002000;
	localparam logic [CP_BITS-1:0] WS_HAIR    = 21'h00200A;
	localparam logic [CP_BITS-1:0] WS_LSEP    = 21'h002028;
	localparam logic [CP_BITS-1:0] WS_PSEP    = 21'h002029;
	localparam logic [CP_BITS-1:0] WS_NNBSP   = 21'h00202F;
	localparam logic [CP_BITS-1:0] WS_MMSP    = 21'h00205F;
	localparam logic [CP_BITS-1:0] WS_IDEO    = 21'h003000;

	typedef enum logic {
		REG_NUL_ENDS_TEXT = 1'b0,
		REG_BYTE_LIMIT    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CP_BITS-1:0]  code_point;
		logic [IDX_BITS-1:0] char_index;
		logic [IDX_BITS-1:0] start_offset;
		logic [NB_BITS-1:0]  char_bytes;
		logic                text_end;
	} char_rec_t;

	function automatic logic is_space_cp(input logic [CP_BITS-1:0] c);
		return (c >= WS_TAB && c <= WS_CR) || c == WS_SPACE || c == WS_NEL
			|| c == WS_NBSP || c == WS_OGHAM || (c >= WS_ENQUAD && c <= WS_HAIR)
			|| c == WS_LSEP || c == WS_PSEP || c == WS_NNBSP || c == WS_MMSP
			|| c == WS_IDEO;
	endfunction

endpackage

>>> src/utf8_stream_decoder.sv
// Streaming UTF-8 decoder. One text byte is taken per cycle whenever the four-entry
// result queue has room; the lead/continuation state update is what holds the input
// to that one byte per cycle. A finished character (or an end-of-text result) is
// written into the queue and then into the output register before it leaves on the
// master side. Output stalls are absorbed by the output register and then by the queue.
// Decoding does no validation: the lead byte alone sets the length. A zero lead byte
// (when enabled by register 0) or a byte at or past the byte limit (register 1) gives
// an end result with tlast high and clears all counters; that byte is not counted.
module utf8_stream_decoder #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte
	input  logic [0:0]  s_tuser,   // restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // code_point, char_index, start_offset, char_bytes
	output logic        m_tlast,   // text_end
	output logic [0:0]  m_tuser    // is_space
);

	logic                 in_fire;
	logic                 push;
	u8sd_pkg::char_rec_t  rec;
	logic                 q_full;
	logic                 q_not_empty;
	u8sd_pkg::char_rec_t  q_head;
	logic                 pop;

	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	u8sd_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_fire   (in_fire),
		.text_byte (s_tdata),
		.restart   (s_tuser[0]),
		.push      (push),
		.rec       (rec)
	);

	u8sd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (rec),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	u8sd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser)
	);

endmodule

>>> src/u8sd_front.sv
module u8sd_front #(
	parameter int COUNT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_index,
	input  logic [15:0]                     cfg_wdata,
	input  logic                            in_fire,
	input  logic [7:0]                      text_byte,
	input  logic                            restart,
	output logic                            push,
	output u8sd_pkg::char_rec_t             rec
);

	localparam int CMP_BITS = (COUNT_BITS > u8sd_pkg::IDX_BITS) ? COUNT_BITS
		: u8sd_pkg::IDX_BITS;

	logic                              nul_ends_q;
	logic [15:0]                       byte_limit_q;
	logic [1:0]                        pend_q, pend_d;
	logic [u8sd_pkg::CP_BITS-1:0]      part_q, part_d;
	logic [2:0]                        len_q, len_d;
	logic [COUNT_BITS-1:0]             cc_q, cc_d;
	logic [COUNT_BITS-1:0]             bc_q, bc_d;
	logic [COUNT_BITS-1:0]             lo_q, lo_d;

	logic [1:0]                        pend_e;
	logic [u8sd_pkg::CP_BITS-1:0]      part_e, part_acc;
	logic [2:0]                        len_e;
	logic [COUNT_BITS-1:0]             cc_e, bc_e, lo_e;
	logic                              end_text;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [u8sd_pkg::IDX_BITS-1:0] clamp(
		input logic [COUNT_BITS-1:0] v
	);
		logic [CMP_BITS-1:0] w;
		w = CMP_BITS'(v);
		return (w > CMP_BITS'(u8sd_pkg::IDX_MAX)) ? u8sd_pkg::IDX_MAX
			: w[u8sd_pkg::IDX_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nul_ends_q   <= 1'b1;
			byte_limit_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (u8sd_pkg::cfg_reg_t'(cfg_index))
				u8sd_pkg::REG_NUL_ENDS_TEXT: nul_ends_q   <= cfg_wdata[0];
				u8sd_pkg::REG_BYTE_LIMIT:    byte_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Restart wipes the text state before this byte is looked at.
	always_comb begin
		pend_e = restart ? '0 : pend_q;
		part_e = restart ? '0 : part_q;
		len_e  = restart ? '0 : len_q;
		cc_e   = restart ? '0 : cc_q;
		bc_e   = restart ? '0 : bc_q;
		lo_e   = restart ? '0 : lo_q;
	end

	assign end_text = (CMP_BITS'(bc_e) >= CMP_BITS'(byte_limit_q))
		|| (pend_e == 2'd0 && text_byte == 8'd0 && nul_ends_q);

	assign part_acc = {part_e[u8sd_pkg::CP_BITS-7:0],
		text_byte[5:0] & u8sd_pkg::CONT_MASK};

	always_comb begin
		pend_d = pend_e;
		part_d = part_e;
		len_d  = len_e;
		cc_d   = cc_e;
		bc_d   = bc_e;
		lo_d   = lo_e;
		push   = 1'b0;
		rec    = '0;
		if (end_text) begin
			push              = 1'b1;
			rec.char_index    = clamp(cc_e);
			rec.start_offset  = clamp(bc_e);
			rec.text_end      = 1'b1;
			pend_d = '0;
			part_d = '0;
			len_d  = '0;
			cc_d   = '0;
			bc_d   = '0;
			lo_d   = '0;
		end else if (pend_e == 2'd0) begin
			lo_d = bc_e;
			bc_d = sat_inc(bc_e);
			if (text_byte < u8sd_pkg::LEAD_TWO) begin
				push             = 1'b1;
				rec.code_point   = u8sd_pkg::CP_BITS'(text_byte);
				rec.char_index   = clamp(cc_e);
				rec.start_offset = clamp(bc_e);
				rec.char_bytes   = 3'd1;
				cc_d   = sat_inc(cc_e);
				part_d = '0;
				len_d  = '0;
			end else if (text_byte < u8sd_pkg::LEAD_THREE) begin
				part_d = u8sd_pkg::CP_BITS'(text_byte[4:0]);
				len_d  = 3'd2;
				pend_d = 2'd1;
			end else if (text_byte < u8sd_pkg::LEAD_FOUR) begin
				part_d = u8sd_pkg::CP_BITS'(text_byte[3:0]);
				len_d  = 3'd3;
				pend_d = 2'd2;
			end else begin
				part_d = u8sd_pkg::CP_BITS'(text_byte[2:0]);
				len_d  = 3'd4;
				pend_d = 2'd3;
			end
		end else begin
			bc_d = sat_inc(bc_e);
			if (pend_e == 2'd1) begin
				push             = 1'b1;
				rec.code_point   = part_acc;
				rec.char_index   = clamp(cc_e);
				rec.start_offset = clamp(lo_e);
				rec.char_bytes   = len_e;
				cc_d   = sat_inc(cc_e);
				pend_d = '0;
				part_d = '0;
				len_d  = '0;
			end else begin
				part_d = part_acc;
				pend_d = pend_e - 2'd1;
			end
		end
		push = push && in_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			part_q <= '0;
			len_q  <= '0;
			cc_q   <= '0;
			bc_q   <= '0;
			lo_q   <= '0;
		end else if (in_fire) begin
			pend_q <= pend_d;
			part_q <= part_d;
			len_q  <= len_d;
			cc_q   <= cc_d;
			bc_q   <= bc_d;
			lo_q   <= lo_d;
		end
	end

endmodule

>>> src/u8sd_queue.sv
module u8sd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  u8sd_pkg::char_rec_t  push_data,
	input  logic                 pop,
	output logic                 full,
	output logic                 not_empty,
	output u8sd_pkg::char_rec_t  head
);

	u8sd_pkg::char_rec_t                 slots_q [u8sd_pkg::QUEUE_DEPTH];
	logic [u8sd_pkg::QPTR_BITS-1:0]      wr_ptr_q, rd_ptr_q;
	logic [u8sd_pkg::QPTR_BITS:0]        count_q;

	assign full      = (count_q == (u8sd_pkg::QPTR_BITS+1)'(u8sd_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/u8sd_back.sv
module u8sd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_not_empty,
	input  u8sd_pkg::char_rec_t  q_head,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [55:0]          m_tdata,
	output logic                 m_tlast,
	output logic [0:0]           m_tuser
);

	logic                 valid_q;
	u8sd_pkg::char_rec_t  rec_q;
	logic                 space_q;

	assign pop = q_not_empty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// End results carry a zero code point, so the flag stays low for them.
	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q   <= q_head;
			space_q <= !q_head.text_end && u8sd_pkg::is_space_cp(q_head.code_point);
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {rec_q.char_bytes, rec_q.start_offset, rec_q.char_index,
		rec_q.code_point};
	assign m_tlast  = rec_q.text_end;
	assign m_tuser  = space_q;

endmodule

>>> src/u8sd_checker.sv
module u8sd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tlast,
	input logic [0:0]  m_tuser
);

	// An end result carries no character.
	a_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[20:0] == 21'd0 && m_tdata[55:53] == 3'd0
			&& m_tuser == 1'b0)
		else $error("end result carries character data");

	// A character result has a byte count from one to four.
	a_char_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[55:53] == 3'd1 || m_tdata[55:53] == 3'd2
			|| m_tdata[55:53] == 3'd3 || m_tdata[55:53] == 3'd4)
		else $error("character result with bad byte count");

	// Whitespace never exceeds U+3000 and is never flagged on an end result.
	// Overlong sequences are not rejected, so any byte count can carry it.
	a_space_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[20:0] <= 21'h003000 && !m_tlast)
		else $error("whitespace flag on impossible code point");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind utf8_stream_decoder u8sd_checker u_checker (.*);
